>>> design/conv5x5_border_normalized_defines.svh
// assertion macros for the 5x5 border-normalized convolution
`ifndef CONV5X5_BORDER_NORMALIZED_DEFINES_SVH
`define CONV5X5_BORDER_NORMALIZED_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define CONV5_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CONV5_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CONV5_ASSERT_NOW(lbl, ante, cons, msg)
`define CONV5_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> design/conv5_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package conv5_pkg;

  localparam int KERNEL_SIZE = 5;
  localparam int KERNEL_TAPS = KERNEL_SIZE * KERNEL_SIZE;
  localparam int FILT_W      = 16;
  localparam int IMG_W_BITS  = 12;
  localparam int IMG_H_BITS  = 13;
  localparam int MAX_HEIGHT  = 4096;
  localparam int MIN_SIZE    = 5;
  localparam int ROW_W       = 14;
  localparam int CFG_IDX_W   = 3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW0    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW1    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW2    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW3    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROW4    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 3'd6;

  localparam logic [IMG_W_BITS-1:0] RESET_WIDTH  = 12'd2048;
  localparam logic [IMG_H_BITS-1:0] RESET_HEIGHT = 13'd2048;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_MAC,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    state_t st;
    logic   pop;
  } back_status_t;

endpackage
`default_nettype wire

>>> design/conv5_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface conv5_in_if #(
  parameter int PIXEL_BITS = 8
);
  logic                  valid;
  logic                  ready;
  logic                  operation;
  logic [PIXEL_BITS-1:0] pixel;

  modport source (output valid, output operation, output pixel, input ready);
  modport sink   (input valid, input operation, input pixel, output ready);
endinterface
`default_nettype wire

>>> design/conv5_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface conv5_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] filtered_value;
  logic               frame_last;

  modport source (output valid, output filtered_value, output frame_last, input ready);
  modport sink   (input valid, input filtered_value, input frame_last, output ready);
endinterface
`default_nettype wire

>>> design/conv5x5_border_normalized.sv
// an item whose result is due takes a row-store read, a pass through the shared
// multiply-accumulate, then one bit a cycle through the restoring divider; other
// items only shift the window and row store after the queue, and an ignored drain
// tick is dropped
// reset clears counters, handshakes and loads the default kernel and frame size;
// the row stores are not cleared
`timescale 1ns / 1ps
`default_nettype none
`include "conv5x5_border_normalized_defines.svh"
module conv5x5_border_normalized #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  parameter int CFG_W      = (5 * COEF_BITS > 13) ? 5 * COEF_BITS : 13
) (
  input wire logic                            clk,
  input wire logic                            rst,
  input wire logic                            cfg_we,
  input wire logic [conv5_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [CFG_W-1:0]                cfg_data,
  conv5_in_if.sink                            pixels,
  conv5_out_if.source                         results
);
  import conv5_pkg::*;

  back_status_t status;

  conv5_in_if #(.PIXEL_BITS(PIXEL_BITS)) queued ();

  conv5_front u_front (
    .clk    (clk),
    .rst    (rst),
    .items  (pixels),
    .queued (queued)
  );

  conv5_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS),
    .COEF_BITS  (COEF_BITS),
    .CFG_W      (CFG_W)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .items     (queued),
    .results   (results),
    .status    (status)
  );

  `CONV5_ASSERT_NOW(a_pop_idle, status.pop, status.st == ST_IDLE, "pop outside idle")
  `CONV5_ASSERT_NEXT(a_pop_next, status.pop, (status.st == ST_SHIFT) || (status.st == ST_IDLE), "bad state after pop")
  `CONV5_ASSERT_NEXT(a_out_wait, (status.st == ST_OUT) && results.valid && !results.ready, status.st == ST_OUT, "result overwritten")
endmodule
`default_nettype wire

>>> design/conv5_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module conv5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end
endmodule
`default_nettype wire

>>> design/conv5_front.sv
`timescale 1ns / 1ps
`default_nettype none
module conv5_front (
  input wire logic clk,
  input wire logic rst,
  conv5_in_if.sink   items,
  conv5_in_if.source queued
);
  import conv5_pkg::*;

  localparam int PB = $bits(items.pixel);

  logic          ent_op  [2];
  logic [PB-1:0] ent_pix [2];
  logic          wptr;
  logic          rptr;
  logic [1:0]    level;
  logic          push;
  logic          pull;

  assign items.ready      = (level != 2'd2);
  assign queued.valid     = (level != 2'd0);
  assign queued.operation = ent_op[rptr];
  assign queued.pixel     = ent_pix[rptr];
  assign push = items.valid && items.ready;
  assign pull = queued.valid && queued.ready;

  always_ff @(posedge clk) begin
    if (push) begin
      // a pixel field is meaningless on a drain tick
      ent_op[wptr]  <= (items.operation == OP_DRAIN) ? OP_DRAIN : OP_PIXEL;
      ent_pix[wptr] <= items.pixel;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      level <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pull) rptr <= ~rptr;
      level <= level + 2'(push) - 2'(pull);
    end
  end
endmodule
`default_nettype wire

>>> design/conv5_back.sv
`timescale 1ns / 1ps
`default_nettype none
module conv5_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int PIXEL_BITS = 8,
  parameter int COEF_BITS  = 8,
  parameter int CFG_W      = 40
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [conv5_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_W-1:0]                  cfg_data,
  conv5_in_if.sink                               items,
  conv5_out_if.source                            results,
  output conv5_pkg::back_status_t                status
);
  import conv5_pkg::*;

  localparam int KS     = KERNEL_SIZE;
  localparam int P      = PIXEL_BITS;
  localparam int CB     = COEF_BITS;
  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = ROW_W;
  localparam int PROD_W = CB + P + 1;
  localparam int ACC_W  = PROD_W + 5;
  localparam int KW     = $clog2(KERNEL_TAPS + 1);
  localparam int DW     = $clog2(ACC_W);
  localparam logic [KS*CB-1:0] COEF_ONES = {KS{CB'(1)}};

  state_t st, st_next;

  logic [KS*CB-1:0]      coef [KS];
  logic [IMG_W_BITS-1:0] img_w;
  logic [IMG_H_BITS-1:0] img_h;
  logic [CW:0]           w_eff;
  logic [IMG_H_BITS-1:0] h_eff;

  logic [RW-1:0] in_row, out_row;
  logic [CW-1:0] in_col, out_col;
  logic          pop, drain, take, emit, last_now;
  logic [P-1:0]  pix_r;
  logic [P-1:0]  win [KS][KS];
  logic [P-1:0]  column [KS];
  logic [(KS-1)*P-1:0] rd_data, wr_data;
  logic [KS-1:0] row_ok, col_ok;
  logic          last_r;

  logic [KW-1:0]            k;
  logic [2:0]               mi, ni;
  logic signed [PROD_W-1:0] prod_r;
  logic                     prod_v_r, prod_en_r;
  logic signed [ACC_W-1:0]  acc;
  logic [4:0]               cnt;
  logic                     neg;
  logic [ACC_W-1:0]         dvd;
  logic [5:0]               rem, rs;
  logic [DW-1:0]            div_k;
  logic signed [ACC_W:0]    q_s, val;
  logic                     out_free;
  logic [CB-1:0]            coef_sel;
  logic [P-1:0]             pix_sel;

  // clamped frame size
  always_comb begin
    if (img_w < IMG_W_BITS'(MIN_SIZE)) w_eff = (CW+1)'(MIN_SIZE);
    else if (14'(img_w) > 14'(MAX_WIDTH)) w_eff = (CW+1)'(MAX_WIDTH);
    else w_eff = (CW+1)'(img_w);
    if (img_h < IMG_H_BITS'(MIN_SIZE)) h_eff = IMG_H_BITS'(MIN_SIZE);
    else if (img_h > IMG_H_BITS'(MAX_HEIGHT)) h_eff = IMG_H_BITS'(MAX_HEIGHT);
    else h_eff = img_h;
  end

  assign pop   = items.valid && items.ready;
  assign drain = (in_row >= RW'(h_eff));
  assign take  = !((items.operation == OP_DRAIN) && !drain);
  assign emit  = (in_row > RW'(2)) || ((in_row == RW'(2)) && (in_col >= CW'(2)));
  assign last_now = (out_row >= RW'(h_eff) - RW'(1)) &&
                    ((CW+1)'(out_col) >= w_eff - (CW+1)'(1));
  assign out_free = !results.valid || results.ready;

  always_comb begin
    for (int m = 0; m < KS - 1; m++) begin
      column[m]           = rd_data[m*P +: P];
    end
    column[KS-1] = pix_r;
    for (int m = 0; m < KS - 1; m++) begin
      wr_data[m*P +: P] = column[m+1];
    end
  end

  conv5_ram #(.WIDTH((KS-1)*P), .DEPTH(MAX_WIDTH)) u_rows (
    .clk     (clk),
    .wr_en   (st == ST_SHIFT),
    .wr_addr (in_col),
    .wr_data (wr_data),
    .rd_en   (pop),
    .rd_addr (in_col),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    st_next = st;
    unique case (st)
      ST_IDLE:  if (pop && take) st_next = ST_SHIFT;
      ST_SHIFT: st_next = emit ? ST_MAC : ST_IDLE;
      ST_MAC:   if (k == KW'(KERNEL_TAPS)) st_next = ST_PREP;
      ST_PREP:  st_next = ST_DIV;
      ST_DIV:   if (div_k == DW'(ACC_W - 1)) st_next = ST_OUT;
      ST_OUT:   if (out_free) st_next = ST_IDLE;
      default:  st_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    items.ready = 1'b0;
    unique case (st)
      ST_IDLE: items.ready = 1'b1;
      default: items.ready = 1'b0;
    endcase
  end

  assign status.st  = st;
  assign status.pop = pop;

  assign coef_sel = coef[mi][ni*CB +: CB];
  assign pix_sel  = win[mi][3'(KS-1) - ni];
  assign rs       = {rem[4:0], dvd[ACC_W-1]};
  assign q_s      = $signed({1'b0, dvd});
  assign val      = (cnt == 5'd0) ? '0 : (neg ? -q_s : q_s);

  always_ff @(posedge clk) begin
    case (st)
      ST_IDLE: begin
        if (pop) pix_r <= drain ? '0 : items.pixel;
      end
      ST_SHIFT: begin
        for (int m = 0; m < KS; m++) begin
          for (int a = KS - 1; a > 0; a--) begin
            win[m][a] <= win[m][a-1];
          end
          win[m][0] <= column[m];
        end
        for (int m = 0; m < KS; m++) begin
          row_ok[m] <= ($signed((RW+2)'(out_row)) + (RW+2)'(m) - (RW+2)'(2) >= 0) &&
                       ($signed((RW+2)'(out_row)) + (RW+2)'(m) - (RW+2)'(2) <
                        $signed((RW+2)'(h_eff)));
          col_ok[m] <= ($signed((CW+3)'(out_col)) + (CW+3)'(m) - (CW+3)'(2) >= 0) &&
                       ($signed((CW+3)'(out_col)) + (CW+3)'(m) - (CW+3)'(2) <
                        $signed((CW+3)'(w_eff)));
        end
        last_r    <= last_now;
        k         <= '0;
        mi        <= '0;
        ni        <= '0;
        prod_v_r  <= 1'b0;
        acc       <= '0;
        cnt       <= '0;
      end
      ST_MAC: begin
        if (prod_v_r && prod_en_r) begin
          acc <= acc + ACC_W'(prod_r);
          cnt <= cnt + 5'd1;
        end
        prod_v_r  <= (k < KW'(KERNEL_TAPS));
        prod_r    <= $signed(coef_sel) * $signed({1'b0, pix_sel});
        prod_en_r <= row_ok[mi] && col_ok[ni];
        k <= k + KW'(1);
        if (ni == 3'(KS - 1)) begin
          ni <= '0;
          mi <= mi + 3'd1;
        end else begin
          ni <= ni + 3'd1;
        end
      end
      ST_PREP: begin
        neg   <= acc[ACC_W-1];
        dvd   <= acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
        rem   <= '0;
        div_k <= '0;
      end
      ST_DIV: begin
        if (rs >= {1'b0, cnt}) begin
          rem <= rs - {1'b0, cnt};
          dvd <= {dvd[ACC_W-2:0], 1'b1};
        end else begin
          rem <= rs;
          dvd <= {dvd[ACC_W-2:0], 1'b0};
        end
        div_k <= div_k + DW'(1);
      end
      default: begin
      end
    endcase
    if (st == ST_OUT && out_free) begin
      results.filtered_value <= FILT_W'(val);
      results.frame_last     <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st            <= ST_IDLE;
      in_row        <= '0;
      in_col        <= '0;
      out_row       <= '0;
      out_col       <= '0;
      results.valid <= 1'b0;
      for (int m = 0; m < KS; m++) coef[m] <= COEF_ONES;
      img_w <= RESET_WIDTH;
      img_h <= RESET_HEIGHT;
    end else begin
      st <= st_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_COEF_ROW0:    coef[0] <= cfg_data[KS*CB-1:0];
          CFG_COEF_ROW1:    coef[1] <= cfg_data[KS*CB-1:0];
          CFG_COEF_ROW2:    coef[2] <= cfg_data[KS*CB-1:0];
          CFG_COEF_ROW3:    coef[3] <= cfg_data[KS*CB-1:0];
          CFG_COEF_ROW4:    coef[4] <= cfg_data[KS*CB-1:0];
          CFG_IMAGE_WIDTH:  img_w   <= cfg_data[IMG_W_BITS-1:0];
          CFG_IMAGE_HEIGHT: img_h   <= cfg_data[IMG_H_BITS-1:0];
          default: ;
        endcase
      end
      if (st == ST_SHIFT) begin
        if (emit && last_now) begin
          in_row  <= '0;
          in_col  <= '0;
          out_row <= '0;
          out_col <= '0;
        end else begin
          if ((CW+1)'(in_col) + (CW+1)'(1) >= w_eff) begin
            in_col <= '0;
            in_row <= in_row + RW'(1);
          end else begin
            in_col <= in_col + CW'(1);
          end
          if (emit) begin
            if ((CW+1)'(out_col) + (CW+1)'(1) >= w_eff) begin
              out_col <= '0;
              out_row <= out_row + RW'(1);
            end else begin
              out_col <= out_col + CW'(1);
            end
          end
        end
      end
      if (st == ST_OUT && out_free) results.valid <= 1'b1;
      else if (results.ready) results.valid <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> tb/conv5x5_border_normalized_tb.sv
`timescale 1ns / 1ps
module conv5x5_border_normalized_tb;
  import conv5_pkg::*;

  localparam int MAX_W = 2048;
  localparam int CYCLE_LIMIT = 4000000;

  typedef struct {
    logic signed [15:0] value;
    bit                 last;
  } filt_result_t;

  class conv_scoreboard;
    logic [39:0]         coef [KERNEL_SIZE];
    logic [11:0]         width_reg;
    logic [12:0]         height_reg;
    logic [7:0]          line_mem [4][MAX_W];
    logic [7:0]          win [KERNEL_SIZE][KERNEL_SIZE];
    int                  in_r, in_c, out_r, out_c;
    filt_result_t        pending [$];
    int                  fails;

    function new();
      for (int m = 0; m < KERNEL_SIZE; m++) coef[m] = 40'h0101010101;
      width_reg = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      for (int m = 0; m < 4; m++)
        for (int c = 0; c < MAX_W; c++) line_mem[m][c] = '0;
      for (int m = 0; m < KERNEL_SIZE; m++)
        for (int n = 0; n < KERNEL_SIZE; n++) win[m][n] = '0;
      in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      fails = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] data);
      case (idx)
        CFG_COEF_ROW0, CFG_COEF_ROW1, CFG_COEF_ROW2, CFG_COEF_ROW3, CFG_COEF_ROW4: begin
          coef[idx] = data;
        end
        CFG_IMAGE_WIDTH: begin
          width_reg = data[11:0];
        end
        CFG_IMAGE_HEIGHT: begin
          height_reg = data[12:0];
        end
        default: ;
      endcase
    endfunction

    function int frame_w();
      if (width_reg < MIN_SIZE) return MIN_SIZE;
      if (width_reg > MAX_W) return MAX_W;
      return width_reg;
    endfunction

    function int frame_h();
      if (height_reg < MIN_SIZE) return MIN_SIZE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function void note_input(logic op, logic [7:0] px);
      int           w, h, col, r, c, taps, sum;
      bit           draining, emit;
      logic [7:0]   column [KERNEL_SIZE];
      logic signed [7:0] k;
      filt_result_t res;
      w = frame_w();
      h = frame_h();
      draining = (in_r >= h);
      if (op == OP_DRAIN && !draining) return;
      col = (in_c < MAX_W) ? in_c : MAX_W - 1;
      for (int m = 0; m < 4; m++) column[m] = line_mem[m][col];
      column[4] = draining ? 8'd0 : px;
      for (int m = 0; m < 4; m++) line_mem[m][col] = column[m + 1];
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        for (int n = KERNEL_SIZE - 1; n > 0; n--) win[m][n] = win[m][n - 1];
        win[m][0] = column[m];
      end
      emit = (in_r > 2) || (in_r == 2 && in_c >= 2);
      in_c++;
      if (in_c >= w) begin
        in_c = 0;
        in_r++;
      end
      if (!emit) return;
      sum = 0;
      taps = 0;
      for (int m = 0; m < KERNEL_SIZE; m++) begin
        r = out_r - 2 + m;
        if (r < 0 || r >= h) continue;
        for (int n = 0; n < KERNEL_SIZE; n++) begin
          c = out_c - 2 + n;
          if (c < 0 || c >= w) continue;
          k = coef[m][8*n +: 8];
          sum += int'(k) * int'(win[m][KERNEL_SIZE - 1 - n]);
          taps++;
        end
      end
      res.value = (taps != 0) ? 16'(sum / taps) : 16'sd0;
      res.last = (out_r >= h - 1) && (out_c >= w - 1);
      pending.push_back(res);
      if (res.last) begin
        in_r = 0; in_c = 0; out_r = 0; out_c = 0;
      end else begin
        out_c++;
        if (out_c >= w) begin
          out_c = 0;
          out_r++;
        end
      end
    endfunction

    function void check_result(logic signed [15:0] value, logic last);
      filt_result_t exp_res;
      if (pending.size() == 0) begin
        $error("unexpected result transfer: filtered_value %0d frame_last %0b", value, last);
        fails++;
        return;
      end
      exp_res = pending.pop_front();
      if (value !== exp_res.value) begin
        $error("filtered_value: expected %0d, actual %0d", exp_res.value, value);
        fails++;
      end
      if (last !== exp_res.last) begin
        $error("frame_last: expected %0b, actual %0b", exp_res.last, last);
        fails++;
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [39:0]          cfg_data;
  bit                   gaps_on;
  int                   cycles;
  conv_scoreboard       sb;

  conv5_in_if #(.PIXEL_BITS(8)) in_ch ();
  conv5_out_if                  out_ch ();

  conv5x5_border_normalized dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pixels   (in_ch.sink),
    .results  (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.operation = OP_PIXEL;
    in_ch.pixel = '0;
    out_ch.ready = 1'b0;
    gaps_on = 1'b1;
    cycles = 0;
    sb = new();
  end

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("conv5x5_border_normalized test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.filtered_value, out_ch.frame_last);
      out_ch.ready <= !(gaps_on && $urandom_range(99) < 6);
    end
  end

  task automatic send_item(logic op, logic [7:0] px);
    while (gaps_on && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.operation <= op;
    in_ch.pixel <= px;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(op, px);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.write_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic set_kernel(logic [39:0] r0, logic [39:0] r1, logic [39:0] r2,
                            logic [39:0] r3, logic [39:0] r4);
    write_reg(CFG_COEF_ROW0, r0);
    write_reg(CFG_COEF_ROW1, r1);
    write_reg(CFG_COEF_ROW2, r2);
    write_reg(CFG_COEF_ROW3, r3);
    write_reg(CFG_COEF_ROW4, r4);
  endtask

  // mode 0: fixed pixel, 1: random, 2: random with noise
  task automatic run_frame(int mode, logic [7:0] fixed_px);
    int          w, h;
    logic [7:0]  px;
    w = sb.frame_w();
    h = sb.frame_h();
    for (int i = 0; i < w * h; i++) begin
      if (mode == 2 && $urandom_range(99) < 8) send_item(OP_DRAIN, 8'($urandom));
      px = (mode == 0) ? fixed_px : 8'($urandom);
      send_item(OP_PIXEL, px);
    end
    for (int i = 0; i < 2 * w + 2; i++) begin
      if (mode == 0) send_item(OP_DRAIN, 8'd0);
      else send_item(logic'($urandom_range(1)), 8'($urandom));
    end
  endtask

  function automatic logic [39:0] rand_row();
    case ($urandom_range(5))
      0: return 40'h8080808080;
      1: return 40'h7f7f7f7f7f;
      default: return {8'($urandom), 32'($urandom)};
    endcase
  endfunction

  initial begin
    int total;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // out-of-range sizes first, then overwritten
    write_reg(CFG_IMAGE_HEIGHT, 40'h1fff);
    write_reg(CFG_IMAGE_WIDTH, 40'hfff);
    write_reg(CFG_IMAGE_WIDTH, 40'd3);
    write_reg(CFG_IMAGE_HEIGHT, 40'd5);
    set_kernel(40'h7f7f7f7f7f, 40'h7f7f7f7f7f, 40'h7f7f7f7f7f, 40'h7f7f7f7f7f,
               40'h7f7f7f7f7f);
    send_item(OP_DRAIN, 8'hff);
    run_frame(0, 8'hff);
    wait_idle();
    set_kernel(40'h8080808080, 40'h8080808080, 40'h8080808080, 40'h8080808080,
               40'h8080808080);
    run_frame(2, 8'h00);
    wait_idle();
    total = 80;
    while (total < 950) begin
      set_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
      write_reg(CFG_IMAGE_WIDTH, 40'($urandom_range(12, 5)));
      write_reg(CFG_IMAGE_HEIGHT, 40'($urandom_range(9, 5)));
      gaps_on = !(total > 300 && total < 500);
      run_frame(2, 8'h00);
      total += sb.frame_w() * (sb.frame_h() + 2) + 2;
      wait_idle();
    end
    gaps_on = 1'b1;
    // small frame, with height clamped up from zero
    write_reg(CFG_IMAGE_WIDTH, 40'd6);
    write_reg(CFG_IMAGE_HEIGHT, 40'd0);
    set_kernel(rand_row(), rand_row(), rand_row(), rand_row(), rand_row());
    run_frame(1, 8'h00);
    wait_idle();
    repeat (200) @(posedge clk);
    if (sb.fails == 0) begin
      $display("conv5x5_border_normalized test passed");
    end else begin
      $display("conv5x5_border_normalized test failed");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+design
design/conv5_pkg.sv
design/conv5_in_if.sv
design/conv5_out_if.sv
design/conv5_ram.sv
design/conv5_front.sv
design/conv5_back.sv
design/conv5x5_border_normalized.sv
tb/conv5x5_border_normalized_tb.sv
